// ----- sv/ntdf_pkg.sv -----
// Package for the number-to-digit-frames block.
// Holds the shared item type and the digit coding constants; no dependencies.
package ntdf_pkg;

	// Widths of the number, of the point position field and of a digit code.
	localparam int VALUE_W = 16;
	localparam int POINT_W = 3;
	localparam int CODE_W  = 8;

	// Digit codes.
	localparam logic [CODE_W-1:0] BLANK_CODE = 8'h0F;
	localparam logic [CODE_W-1:0] POINT_BIT  = 8'h80;

	// Divide by ten: q = (n * RECIP) >> RECIP_SHIFT is exact for 16-bit n.
	localparam logic [VALUE_W:0] RECIP       = 17'd52429;
	localparam int               RECIP_SHIFT = 19;

	// Part of the number still to convert, with its point position.
	typedef struct packed {
		logic [VALUE_W-1:0] rest;
		logic [POINT_W-1:0] point;
	} ntdf_item_t;

endpackage

// ----- sv/ntdf_cell.sv -----
// One cell of the digit chain: peels the lowest decimal digit off the number.
// Depends on ntdf_pkg.
module ntdf_cell import ntdf_pkg::*; #(
	parameter int DIGIT_COUNT = 5,
	parameter int INDEX       = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  ntdf_item_t                    in_item,
	input  logic [DIGIT_COUNT*CODE_W-1:0] in_codes,
	output logic                          out_valid,
	output ntdf_item_t                    out_item,
	output logic [DIGIT_COUNT*CODE_W-1:0] out_codes
);

	localparam logic [3:0] IDX   = 4'(INDEX);
	localparam logic [3:0] COUNT = 4'(DIGIT_COUNT);

	logic                          valid_q;
	ntdf_item_t                    item_q;
	logic [DIGIT_COUNT*CODE_W-1:0] codes_q;

	logic [2*VALUE_W-1:0] prod;
	logic [VALUE_W-1:0]   quot;
	logic [VALUE_W-1:0]   quot10;
	logic [VALUE_W-1:0]   remd;
	logic                 has_point;
	logic                 shielded;
	logic                 blank;
	logic [CODE_W-1:0]    code;
	ntdf_item_t           next_item;
	logic [DIGIT_COUNT*CODE_W-1:0] next_codes;

	// Divide by ten through a reciprocal multiply, then form the digit code.
	always_comb begin
		prod      = 32'(in_item.rest) * 32'(RECIP);
		quot      = 16'(prod >> RECIP_SHIFT);
		quot10    = 16'({quot, 3'b000}) + 16'({quot, 1'b0});
		remd      = in_item.rest - quot10;
		has_point = {1'b0, in_item.point} < COUNT;
		shielded  = (IDX == 4'd0) || (has_point && (IDX <= {1'b0, in_item.point}));
		blank     = (in_item.rest == '0) && !shielded;
		next_item = in_item;
		if (blank) begin
			code = BLANK_CODE;
		end else begin
			code = {4'b0000, remd[3:0]};
			next_item.rest = quot;
		end
		if (has_point && ({1'b0, in_item.point} == IDX)) begin
			code = code | POINT_BIT;
		end
		next_codes = in_codes;
		next_codes[INDEX*CODE_W +: CODE_W] = code;
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (en) begin
			item_q  <= next_item;
			codes_q <= next_codes;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;
	assign out_codes = codes_q;

endmodule

// ----- sv/ntdf_frames.sv -----
// Frame sender: holds a finished set of digit codes and sends one frame per cycle while frame_ready is high.
// Depends on ntdf_pkg.
module ntdf_frames import ntdf_pkg::*; #(
	parameter int DIGIT_COUNT = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [DIGIT_COUNT*CODE_W-1:0] codes,
	output logic                          can_take,
	output logic                          frame_valid,
	input  logic                          frame_ready,
	output logic [2:0]                    frame_address,
	output logic [CODE_W-1:0]             frame_code,
	output logic                          frame_last
);

	localparam int IW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

	logic                          busy_q;
	logic [IW-1:0]                 idx_q;
	logic [DIGIT_COUNT*CODE_W-1:0] codes_q;
	logic [3:0]                    addr_w;
	logic                          sent;

	// Frame fields come from the current digit index.
	always_comb begin
		addr_w        = 4'(idx_q) + 4'd1;
		frame_address = addr_w[2:0];
		frame_code    = codes_q[idx_q*CODE_W +: CODE_W];
		frame_last    = (idx_q == IW'(DIGIT_COUNT - 1));
		frame_valid   = busy_q;
		sent          = busy_q && frame_ready;
		can_take      = !busy_q || (sent && frame_last);
	end

	// Run control: a new set starts at digit 0, otherwise step on each sent frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (sent) begin
			if (frame_last) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	// Digit codes of the run being sent.
	always_ff @(posedge clk) begin
		if (load) begin
			codes_q <= codes;
		end
	end

endmodule

// ----- sv/number_to_digit_frames.sv -----
// Number to digit frames: one number in, DIGIT_COUNT display frames out, lowest digit first.
// An accepted item passes the digit chain registers and is loaded into the frame sender.
// The sender sends one frame a cycle while m_tready is high, and takes the next item as it
// sends the last frame; the chain takes a new item every cycle while the sender keeps up.
// Reset: arst_n clears all valid bits and the sender; no item or frame is pending after it.
// Depends on ntdf_pkg, ntdf_cell and ntdf_frames.
module number_to_digit_frames import ntdf_pkg::*; #(
	parameter int DIGIT_COUNT = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [15:0] value, [18:16] point_position, [23:19] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [2:0] digit_address, [10:3] digit_code, [15:11] zero
	output logic        m_tlast
);

	logic                          en;
	logic                          can_take;
	logic                          load;
	logic                          chain_valid [DIGIT_COUNT+1];
	ntdf_item_t                    chain_item  [DIGIT_COUNT+1];
	logic [DIGIT_COUNT*CODE_W-1:0] chain_codes [DIGIT_COUNT+1];
	logic [2:0]                    frame_address;
	logic [CODE_W-1:0]             frame_code;

	// The chain moves whenever its last stage is empty or the sender takes it.
	assign en       = !chain_valid[DIGIT_COUNT] || can_take;
	assign load     = chain_valid[DIGIT_COUNT] && can_take;
	assign s_tready = en;

	// Head of the chain.
	assign chain_valid[0]      = s_tvalid;
	assign chain_item[0].rest  = s_tdata[15:0];
	assign chain_item[0].point = s_tdata[18:16];
	assign chain_codes[0]      = '0;

	// One cell per digit.
	for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_cell
		ntdf_cell #(
			.DIGIT_COUNT (DIGIT_COUNT),
			.INDEX       (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (chain_valid[g]),
			.in_item   (chain_item[g]),
			.in_codes  (chain_codes[g]),
			.out_valid (chain_valid[g+1]),
			.out_item  (chain_item[g+1]),
			.out_codes (chain_codes[g+1])
		);
	end

	// Frame sender.
	ntdf_frames #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_frames (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.codes         (chain_codes[DIGIT_COUNT]),
		.can_take      (can_take),
		.frame_valid   (m_tvalid),
		.frame_ready   (m_tready),
		.frame_address (frame_address),
		.frame_code    (frame_code),
		.frame_last    (m_tlast)
	);

	assign m_tdata = {5'b00000, frame_code, frame_address};

endmodule
